// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/mos_pkg.sv =====
// Package for the marker outlier smoother: constants, codes and types
`timescale 1ns / 1ps

package mos_pkg;

    localparam int MARKERS_DEFAULT = 16;
    localparam int MARKER_ID_W     = 4;
    localparam int POS_W           = 32;
    localparam int TIME_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int GAIN_W          = 17;
    localparam int DT_W            = 20;
    localparam int STEP_W          = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DT     = 2'd3;

    localparam logic [31:0]       MAX_JUMP_RESET       = 32'd11796;
    localparam logic [31:0]       MAX_VELOCITY_RESET   = 32'd393216;
    localparam logic [GAIN_W-1:0] SMOOTHING_GAIN_RESET = 17'd39322;
    localparam logic [DT_W-1:0]   DEFAULT_DT_RESET     = 20'd33333;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h1_0000;

    // 10^12 (us^2 per s^2) split into 32-bit halves
    localparam logic [31:0] SCALE_LO = 32'hD4A5_1000;
    localparam logic [31:0] SCALE_HI = 32'h0000_00E8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SEEDED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SMOOTHED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTLIER_HELD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID_HELD = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID_ZERO = 3'd4;

    // multiplier sequence
    localparam logic [STEP_W-1:0] STEP_SQ_X   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_Y   = 5'd1;
    localparam logic [STEP_W-1:0] STEP_SQ_Z   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_JUMP   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_VDT    = 5'd4;
    localparam logic [STEP_W-1:0] STEP_S0_LO  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_S0_HI  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_S1_LO  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_S1_HI  = 5'd8;
    localparam logic [STEP_W-1:0] STEP_S2_LO  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_S2_HI  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_V_LL   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_V_HL_A = 5'd12;
    localparam logic [STEP_W-1:0] STEP_V_HL_B = 5'd13;
    localparam logic [STEP_W-1:0] STEP_V_HH   = 5'd14;
    localparam logic [STEP_W-1:0] STEP_BL_X   = 5'd15;
    localparam logic [STEP_W-1:0] STEP_BL_Y   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_BL_Z   = 5'd17;
    localparam logic [STEP_W-1:0] STEP_DRAIN  = 5'd18;

    typedef enum logic [1:0] {
        K_SEED,
        K_TRACK,
        K_INV_HELD,
        K_INV_ZERO
    } kind_t;

    typedef struct packed {
        logic [POS_W-1:0]  raw_x;
        logic [POS_W-1:0]  raw_y;
        logic [POS_W-1:0]  raw_z;
        logic [POS_W-1:0]  est_x;
        logic [POS_W-1:0]  est_y;
        logic [POS_W-1:0]  est_z;
        logic [TIME_W-1:0] time_v;
    } entry_t;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] n;
        begin
            d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
            n = -d;
            abs_diff = d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
        end
    endfunction

    function automatic logic signed [POS_W:0] sdiff(input logic [POS_W-1:0] a,
                                                    input logic [POS_W-1:0] b);
        begin
            sdiff = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
        end
    endfunction

endpackage

// ===== rtl/mos_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps

module mos_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/marker_outlier_smoother.sv =====
// Top level of the marker outlier smoother
`timescale 1ns / 1ps

// Cleans a stream of 3D marker samples, one item at a time. Per-marker raw
// position, estimate and last time sit in one RAM of MARKERS entries; a flag
// per marker marks it seeded and is cleared by reset, so no clearing pass is
// needed. A tracked sample (valid, marker already seeded) occupies the block
// from acceptance to the next acceptance: the RAM read, the shared 33x33
// multiplier sequence (squared step, squared limits, the 10^12 speed scaling
// and the three blend products, plus a drain step), the outlier decision and
// write-back, and the return to idle, where the next item is taken. A seeding
// or invalid sample skips the multiplier sequence. The result is held in an
// output register; while it waits the next item is already accepted, and
// write-back of that item waits only for the output register to free up.

`include "assert_macros.svh"

module marker_outlier_smoother #(
    parameter int MARKERS = mos_pkg::MARKERS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mos_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mos_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mos_pkg::MARKER_ID_W-1:0]      marker_index,
    input  logic signed [mos_pkg::POS_W-1:0]     pos_x,
    input  logic signed [mos_pkg::POS_W-1:0]     pos_y,
    input  logic signed [mos_pkg::POS_W-1:0]     pos_z,
    input  logic [mos_pkg::TIME_W-1:0]           time_stamp,
    input  logic                                 sample_valid,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mos_pkg::MARKER_ID_W-1:0]      marker_id,
    output logic signed [mos_pkg::POS_W-1:0]     est_x,
    output logic signed [mos_pkg::POS_W-1:0]     est_y,
    output logic signed [mos_pkg::POS_W-1:0]     est_z,
    output logic [mos_pkg::STATUS_W-1:0]         status
);

    localparam int IDX_W   = (MARKERS > 1) ? $clog2(MARKERS) : 1;
    localparam int IDS     = 2 ** mos_pkg::MARKER_ID_W;
    localparam int ENTRY_W = $bits(mos_pkg::entry_t);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]                    max_jump_reg;
    logic [31:0]                    max_velocity_reg;
    logic [mos_pkg::GAIN_W-1:0]     smoothing_gain_reg;
    logic [mos_pkg::DT_W-1:0]       default_dt_reg;

    logic [MARKERS-1:0]             seeded_reg;

    logic [mos_pkg::MARKER_ID_W-1:0] id_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [mos_pkg::POS_W-1:0]      px_reg, py_reg, pz_reg;
    logic [mos_pkg::TIME_W-1:0]     t_reg;
    logic                           sv_reg;
    mos_pkg::kind_t                 kind_reg, kind_next;

    logic [mos_pkg::POS_W-1:0]      mag_x_reg, mag_y_reg, mag_z_reg;
    logic signed [mos_pkg::POS_W:0] diff_x_reg, diff_y_reg, diff_z_reg;
    logic [30:0]                    dt_reg;
    logic [mos_pkg::GAIN_W-1:0]     gain_reg;

    logic [mos_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [mos_pkg::STEP_W-1:0]     prod_step_reg;
    logic                           prod_vld_reg;
    logic signed [65:0]             prod_reg;
    logic signed [32:0]             op_a, op_b;

    logic [65:0]                    s_reg;
    logic [63:0]                    jl_reg;
    logic [62:0]                    vdt_reg;
    logic [127:0]                   sc_reg, vl_reg;
    logic [127:0]                   prod_wide;
    logic signed [65:0]             round_sum;
    logic [mos_pkg::POS_W-1:0]      nx_reg, ny_reg, nz_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [mos_pkg::MARKER_ID_W-1:0] out_id_reg;
    logic [mos_pkg::POS_W-1:0]      out_x_reg, out_y_reg, out_z_reg;
    logic [mos_pkg::STATUS_W-1:0]   out_status_reg;

    logic                           accept;
    logic                           done_fire;
    logic                           outlier;
    logic [IDX_W-1:0]               in_idx;
    logic [mos_pkg::TIME_W-1:0]     t_diff;
    logic                           ram_we;
    mos_pkg::entry_t                rd;
    mos_pkg::entry_t                wr;
    logic [ENTRY_W-1:0]             ram_rdata;
    logic [mos_pkg::STATUS_W-1:0]   status_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // marker index folded onto the entries present
    always_comb
    begin
        in_idx = '0;
        for (int i = 0; i < IDS; i++)
        begin
            if (marker_index == mos_pkg::MARKER_ID_W'(i))
            begin
                in_idx = IDX_W'(i % MARKERS);
            end
        end
    end

    mos_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MARKERS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    assign rd     = mos_pkg::entry_t'(ram_rdata);
    assign t_diff = t_reg - rd.time_v;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_jump_reg       <= mos_pkg::MAX_JUMP_RESET;
            max_velocity_reg   <= mos_pkg::MAX_VELOCITY_RESET;
            smoothing_gain_reg <= mos_pkg::SMOOTHING_GAIN_RESET;
            default_dt_reg     <= mos_pkg::DEFAULT_DT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mos_pkg::CFG_MAX_JUMP:       max_jump_reg       <= cfg_data;
                mos_pkg::CFG_MAX_VELOCITY:   max_velocity_reg   <= cfg_data;
                mos_pkg::CFG_SMOOTHING_GAIN:
                    smoothing_gain_reg <= cfg_data[mos_pkg::GAIN_W-1:0];
                mos_pkg::CFG_DEFAULT_DT:
                    default_dt_reg <= cfg_data[mos_pkg::DT_W-1:0];
            endcase
        end
    end

    // item classification on the read cycle
    always_comb
    begin
        if (!sv_reg)
        begin
            kind_next = seeded_reg[idx_reg] ? mos_pkg::K_INV_HELD : mos_pkg::K_INV_ZERO;
        end
        else
        begin
            kind_next = seeded_reg[idx_reg] ? mos_pkg::K_TRACK : mos_pkg::K_SEED;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                step_next  = '0;
                state_next = (kind_next == mos_pkg::K_TRACK) ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                if (step_reg == mos_pkg::STEP_DRAIN)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = done_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seeded_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            prod_vld_reg  <= (state_reg == S_MUL) && (step_reg != mos_pkg::STEP_DRAIN);
            out_valid_reg <= out_valid_next;
            if (done_fire && (kind_reg == mos_pkg::K_SEED))
            begin
                seeded_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // multiplier operand selection
    always_comb
    begin
        unique case (step_reg)
            mos_pkg::STEP_SQ_X:
            begin
                op_a = $signed({1'b0, mag_x_reg});
                op_b = $signed({1'b0, mag_x_reg});
            end
            mos_pkg::STEP_SQ_Y:
            begin
                op_a = $signed({1'b0, mag_y_reg});
                op_b = $signed({1'b0, mag_y_reg});
            end
            mos_pkg::STEP_SQ_Z:
            begin
                op_a = $signed({1'b0, mag_z_reg});
                op_b = $signed({1'b0, mag_z_reg});
            end
            mos_pkg::STEP_JUMP:
            begin
                op_a = $signed({1'b0, max_jump_reg});
                op_b = $signed({1'b0, max_jump_reg});
            end
            mos_pkg::STEP_VDT:
            begin
                op_a = $signed({1'b0, max_velocity_reg});
                op_b = $signed({2'b00, dt_reg});
            end
            mos_pkg::STEP_S0_LO:
            begin
                op_a = $signed({1'b0, s_reg[31:0]});
                op_b = $signed({1'b0, mos_pkg::SCALE_LO});
            end
            mos_pkg::STEP_S0_HI:
            begin
                op_a = $signed({1'b0, s_reg[31:0]});
                op_b = $signed({1'b0, mos_pkg::SCALE_HI});
            end
            mos_pkg::STEP_S1_LO:
            begin
                op_a = $signed({1'b0, s_reg[63:32]});
                op_b = $signed({1'b0, mos_pkg::SCALE_LO});
            end
            mos_pkg::STEP_S1_HI:
            begin
                op_a = $signed({1'b0, s_reg[63:32]});
                op_b = $signed({1'b0, mos_pkg::SCALE_HI});
            end
            mos_pkg::STEP_S2_LO:
            begin
                op_a = $signed({31'd0, s_reg[65:64]});
                op_b = $signed({1'b0, mos_pkg::SCALE_LO});
            end
            mos_pkg::STEP_S2_HI:
            begin
                op_a = $signed({31'd0, s_reg[65:64]});
                op_b = $signed({1'b0, mos_pkg::SCALE_HI});
            end
            mos_pkg::STEP_V_LL:
            begin
                op_a = $signed({1'b0, vdt_reg[31:0]});
                op_b = $signed({1'b0, vdt_reg[31:0]});
            end
            mos_pkg::STEP_V_HL_A, mos_pkg::STEP_V_HL_B:
            begin
                op_a = $signed({2'b00, vdt_reg[62:32]});
                op_b = $signed({1'b0, vdt_reg[31:0]});
            end
            mos_pkg::STEP_V_HH:
            begin
                op_a = $signed({2'b00, vdt_reg[62:32]});
                op_b = $signed({2'b00, vdt_reg[62:32]});
            end
            mos_pkg::STEP_BL_X:
            begin
                op_a = $signed({16'd0, gain_reg});
                op_b = diff_x_reg;
            end
            mos_pkg::STEP_BL_Y:
            begin
                op_a = $signed({16'd0, gain_reg});
                op_b = diff_y_reg;
            end
            mos_pkg::STEP_BL_Z:
            begin
                op_a = $signed({16'd0, gain_reg});
                op_b = diff_z_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_wide = {64'd0, prod_reg[63:0]};
    assign round_sum = prod_reg + 66'sd32768;

    // datapath: operand capture, multiply, accumulate
    always_ff @(posedge clk)
    begin
        prod_reg      <= op_a * op_b;
        prod_step_reg <= step_reg;

        if (accept)
        begin
            id_reg  <= marker_index;
            idx_reg <= in_idx;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            t_reg   <= time_stamp;
            sv_reg  <= sample_valid;
        end

        if (state_reg == S_READ)
        begin
            kind_reg   <= kind_next;
            mag_x_reg  <= mos_pkg::abs_diff(px_reg, rd.raw_x);
            mag_y_reg  <= mos_pkg::abs_diff(py_reg, rd.raw_y);
            mag_z_reg  <= mos_pkg::abs_diff(pz_reg, rd.raw_z);
            diff_x_reg <= mos_pkg::sdiff(px_reg, rd.est_x);
            diff_y_reg <= mos_pkg::sdiff(py_reg, rd.est_y);
            diff_z_reg <= mos_pkg::sdiff(pz_reg, rd.est_z);
            dt_reg     <= ((t_diff != '0) && !t_diff[31]) ? t_diff[30:0]
                                                          : 31'(default_dt_reg);
            gain_reg   <= (smoothing_gain_reg > mos_pkg::GAIN_ONE) ? mos_pkg::GAIN_ONE
                                                                  : smoothing_gain_reg;
            s_reg      <= '0;
            sc_reg     <= '0;
            vl_reg     <= '0;
        end

        if (prod_vld_reg)
        begin
            unique case (prod_step_reg)
                mos_pkg::STEP_SQ_X, mos_pkg::STEP_SQ_Y, mos_pkg::STEP_SQ_Z:
                    s_reg <= s_reg + {2'b00, prod_reg[63:0]};
                mos_pkg::STEP_JUMP:
                    jl_reg <= prod_reg[63:0];
                mos_pkg::STEP_VDT:
                    vdt_reg <= prod_reg[62:0];
                mos_pkg::STEP_S0_LO:
                    sc_reg <= sc_reg + prod_wide;
                mos_pkg::STEP_S0_HI, mos_pkg::STEP_S1_LO:
                    sc_reg <= sc_reg + (prod_wide << 32);
                mos_pkg::STEP_S1_HI, mos_pkg::STEP_S2_LO:
                    sc_reg <= sc_reg + (prod_wide << 64);
                mos_pkg::STEP_S2_HI:
                    sc_reg <= sc_reg + (prod_wide << 96);
                mos_pkg::STEP_V_LL:
                    vl_reg <= vl_reg + prod_wide;
                mos_pkg::STEP_V_HL_A, mos_pkg::STEP_V_HL_B:
                    vl_reg <= vl_reg + (prod_wide << 32);
                mos_pkg::STEP_V_HH:
                    vl_reg <= vl_reg + (prod_wide << 64);
                mos_pkg::STEP_BL_X:
                    nx_reg <= rd.est_x + round_sum[47:16];
                mos_pkg::STEP_BL_Y:
                    ny_reg <= rd.est_y + round_sum[47:16];
                mos_pkg::STEP_BL_Z:
                    nz_reg <= rd.est_z + round_sum[47:16];
                default:
                begin
                end
            endcase
        end

        if (done_fire)
        begin
            out_id_reg     <= id_reg;
            out_x_reg      <= (kind_reg == mos_pkg::K_INV_ZERO) ? '0 : wr.est_x;
            out_y_reg      <= (kind_reg == mos_pkg::K_INV_ZERO) ? '0 : wr.est_y;
            out_z_reg      <= (kind_reg == mos_pkg::K_INV_ZERO) ? '0 : wr.est_z;
            out_status_reg <= status_next;
        end
    end

    // outlier decision and write-back
    assign outlier = (s_reg > {2'b00, jl_reg}) || (sc_reg > vl_reg);
    assign ram_we  = done_fire && (kind_reg != mos_pkg::K_INV_ZERO);

    always_comb
    begin
        wr = rd;
        wr.time_v = t_reg;
        unique case (kind_reg)
            mos_pkg::K_SEED:
            begin
                wr.raw_x = px_reg;
                wr.raw_y = py_reg;
                wr.raw_z = pz_reg;
                wr.est_x = px_reg;
                wr.est_y = py_reg;
                wr.est_z = pz_reg;
                status_next = mos_pkg::ST_SEEDED;
            end
            mos_pkg::K_TRACK:
            begin
                wr.raw_x = px_reg;
                wr.raw_y = py_reg;
                wr.raw_z = pz_reg;
                if (outlier)
                begin
                    status_next = mos_pkg::ST_OUTLIER_HELD;
                end
                else
                begin
                    wr.est_x = nx_reg;
                    wr.est_y = ny_reg;
                    wr.est_z = nz_reg;
                    status_next = mos_pkg::ST_SMOOTHED;
                end
            end
            mos_pkg::K_INV_HELD:
            begin
                status_next = mos_pkg::ST_INVALID_HELD;
            end
            mos_pkg::K_INV_ZERO:
            begin
                status_next = mos_pkg::ST_INVALID_ZERO;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign marker_id = out_id_reg;
    assign est_x     = $signed(out_x_reg);
    assign est_y     = $signed(out_y_reg);
    assign est_z     = $signed(out_z_reg);
    assign status    = out_status_reg;

    `ASSERT_IMPLIES(a_we_in_done, ram_we, state_reg == S_DONE, "state written outside write-back")
    `ASSERT_IMPLIES(a_track_seeded, state_reg == S_MUL, seeded_reg[idx_reg], "tracking unseeded marker")
    `ASSERT_IMPLIES(a_step_range, state_reg == S_MUL, step_reg <= mos_pkg::STEP_DRAIN, "step overrun")
    `ASSERT_NEXT(a_seed_flag, ram_we && kind_reg == mos_pkg::K_SEED, seeded_reg[$past(idx_reg)], "seed flag not set")
    `ASSERT_NEXT(a_result_held, done_fire, out_valid_reg, "result not presented")

endmodule

// ===== tb/marker_outlier_smoother_test.sv =====
// Testbench for the marker outlier smoother: directed and random samples checked by a scoreboard
`timescale 1ns / 1ps

module marker_outlier_smoother_test;
    import mos_pkg::*;

    localparam int MARKERS = MARKERS_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic [MARKER_ID_W-1:0] marker;
        logic [POS_W-1:0]       x;
        logic [POS_W-1:0]       y;
        logic [POS_W-1:0]       z;
        logic [TIME_W-1:0]      stamp;
        logic                   present;
    } sample_t;

    typedef struct {
        logic [MARKER_ID_W-1:0] marker;
        logic [POS_W-1:0]       x;
        logic [POS_W-1:0]       y;
        logic [POS_W-1:0]       z;
        logic [STATUS_W-1:0]    status;
    } estimate_t;

    class estimate_book;
        logic               seeded [MARKERS];
        logic [POS_W-1:0]   raw_x [MARKERS];
        logic [POS_W-1:0]   raw_y [MARKERS];
        logic [POS_W-1:0]   raw_z [MARKERS];
        logic [POS_W-1:0]   est_x [MARKERS];
        logic [POS_W-1:0]   est_y [MARKERS];
        logic [POS_W-1:0]   est_z [MARKERS];
        logic [TIME_W-1:0]  seen_at [MARKERS];
        logic [31:0]        max_jump;
        logic [31:0]        max_speed;
        logic [GAIN_W-1:0]  gain;
        logic [DT_W-1:0]    fallback_dt;
        estimate_t          due_estimates [$];
        int                 mismatches;

        function new();
            foreach (seeded[i])
            begin
                seeded[i] = 1'b0;
            end
            max_jump    = MAX_JUMP_RESET;
            max_speed   = MAX_VELOCITY_RESET;
            gain        = SMOOTHING_GAIN_RESET;
            fallback_dt = DEFAULT_DT_RESET;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_JUMP:       max_jump = data;
                CFG_MAX_VELOCITY:   max_speed = data;
                CFG_SMOOTHING_GAIN: gain = data[GAIN_W-1:0];
                CFG_DEFAULT_DT:     fallback_dt = data[DT_W-1:0];
                default:            ;
            endcase
        endfunction

        function int pending();
            return due_estimates.size();
        endfunction

        function longint unsigned step_sq(logic [POS_W-1:0] now, logic [POS_W-1:0] prev);
            longint d;
            longint unsigned m;
            d = longint'($signed(now)) - longint'($signed(prev));
            m = (d < 0) ? -d : d;
            return m * m;
        endfunction

        // round half up: floor of the weighted sum plus one half
        function logic [POS_W-1:0] blend(logic [POS_W-1:0] raw, logic [POS_W-1:0] est,
                                         logic [GAIN_W-1:0] g);
            longint v;
            v = longint'(g) * longint'($signed(raw))
                + (longint'(GAIN_ONE) - longint'(g)) * longint'($signed(est)) + 32768;
            return POS_W'(v >>> 16);
        endfunction

        function void take_sample(sample_t s);
            estimate_t         r;
            int unsigned       k;
            logic [31:0]       gap;
            logic [63:0]       dt;
            logic [63:0]       reach;
            logic [127:0]      span_sq;
            logic [127:0]      jump_sq;
            logic [127:0]      span_scaled;
            logic [127:0]      speed_sq;
            logic [GAIN_W-1:0] g;
            k = s.marker;
            r.marker = s.marker;
            if (!s.present)
            begin
                if (seeded[k])
                begin
                    seen_at[k] = s.stamp;
                    r.x = est_x[k];
                    r.y = est_y[k];
                    r.z = est_z[k];
                    r.status = ST_INVALID_HELD;
                end
                else
                begin
                    r.x = '0;
                    r.y = '0;
                    r.z = '0;
                    r.status = ST_INVALID_ZERO;
                end
            end
            else
            begin
                if (!seeded[k])
                begin
                    seeded[k] = 1'b1;
                    est_x[k] = s.x;
                    est_y[k] = s.y;
                    est_z[k] = s.z;
                    r.status = ST_SEEDED;
                end
                else
                begin
                    gap = s.stamp - seen_at[k];
                    dt = (gap != 0 && !gap[31]) ? 64'(gap) : 64'(fallback_dt);
                    span_sq = 128'(step_sq(s.x, raw_x[k])) + 128'(step_sq(s.y, raw_y[k]))
                              + 128'(step_sq(s.z, raw_z[k]));
                    jump_sq = 128'(max_jump) * 128'(max_jump);
                    span_scaled = span_sq * 128'd1000000000000;
                    reach = 64'(max_speed) * dt;
                    speed_sq = 128'(reach) * 128'(reach);
                    if (span_sq > jump_sq || span_scaled > speed_sq)
                    begin
                        r.status = ST_OUTLIER_HELD;
                    end
                    else
                    begin
                        g = (gain > GAIN_ONE) ? GAIN_ONE : gain;
                        est_x[k] = blend(s.x, est_x[k], g);
                        est_y[k] = blend(s.y, est_y[k], g);
                        est_z[k] = blend(s.z, est_z[k], g);
                        r.status = ST_SMOOTHED;
                    end
                end
                raw_x[k] = s.x;
                raw_y[k] = s.y;
                raw_z[k] = s.z;
                seen_at[k] = s.stamp;
                r.x = est_x[k];
                r.y = est_y[k];
                r.z = est_z[k];
            end
            due_estimates = {due_estimates, r};
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_estimate(estimate_t got);
            estimate_t want;
            if (due_estimates.size() == 0)
            begin
                report($sformatf("unexpected item for marker %0d", got.marker));
                return;
            end
            want = due_estimates.pop_front();
            if (got.marker !== want.marker)
                report($sformatf("marker_id got %0d want %0d", got.marker, want.marker));
            if (got.x !== want.x)
                report($sformatf("marker %0d est_x got %h want %h", want.marker, got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("marker %0d est_y got %h want %h", want.marker, got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("marker %0d est_z got %h want %h", want.marker, got.z, want.z));
            if (got.status !== want.status)
                report($sformatf("marker %0d status got %0d want %0d",
                                 want.marker, got.status, want.status));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [MARKER_ID_W-1:0] marker_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TIME_W-1:0]      time_stamp;
    logic                   sample_valid;
    logic                   out_valid;
    logic                   out_ready;
    logic [MARKER_ID_W-1:0] marker_id;
    logic signed [POS_W-1:0] est_x;
    logic signed [POS_W-1:0] est_y;
    logic signed [POS_W-1:0] est_z;
    logic [STATUS_W-1:0]    status;

    estimate_book book;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  cycle_count = 0;

    // what the sender has already put on the wire, per marker
    logic              gen_seeded [MARKERS];
    logic [POS_W-1:0]  gen_x [MARKERS];
    logic [POS_W-1:0]  gen_y [MARKERS];
    logic [POS_W-1:0]  gen_z [MARKERS];
    logic [TIME_W-1:0] gen_t [MARKERS];

    marker_outlier_smoother #(.MARKERS(MARKERS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .marker_index (marker_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .time_stamp   (time_stamp),
        .sample_valid (sample_valid),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .marker_id    (marker_id),
        .est_x        (est_x),
        .est_y        (est_y),
        .est_z        (est_z),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = !(stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch_results
        estimate_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.marker = marker_id;
            got.x = est_x;
            got.y = est_y;
            got.z = est_z;
            got.status = status;
            book.check_estimate(got);
        end
    end

    function automatic sample_t mk(logic [MARKER_ID_W-1:0] marker, logic [POS_W-1:0] x,
                                   logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                                   logic [TIME_W-1:0] stamp, logic present);
        sample_t s;
        s.marker = marker;
        s.x = x;
        s.y = y;
        s.z = z;
        s.stamp = stamp;
        s.present = present;
        return s;
    endfunction

    function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] base, int unsigned span);
        return base + POS_W'($urandom_range(2 * span)) - POS_W'(span);
    endfunction

    function automatic sample_t next_sample(int unsigned span);
        sample_t     s;
        int unsigned k;
        int unsigned roll;
        k = $urandom_range(MARKERS - 1);
        roll = $urandom_range(99);
        s.marker = MARKER_ID_W'(k);
        s.x = $urandom;
        s.y = $urandom;
        s.z = $urandom;
        s.stamp = gen_t[k] + $urandom_range(60000, 5000);
        s.present = 1'b1;
        if (roll < 6)
        begin
            s.stamp = $urandom;
            s.present = 1'($urandom_range(1));
        end
        else if (roll < 14)
        begin
            s.present = 1'b0;
        end
        else if (gen_seeded[k])
        begin
            // wide step, stale or repeated time, very short time, else a normal track step
            if (roll < 24)
            begin
                s.x = nudge(gen_x[k], span * 8);
                s.y = nudge(gen_y[k], span * 8);
                s.z = nudge(gen_z[k], span * 8);
            end
            else
            begin
                s.x = nudge(gen_x[k], span);
                s.y = nudge(gen_y[k], span);
                s.z = nudge(gen_z[k], span);
            end
            if (roll >= 24 && roll < 32)
                s.stamp = gen_t[k] - $urandom_range(3) * $urandom_range(5000);
            else if (roll >= 32 && roll < 36)
                s.stamp = gen_t[k] + $urandom_range(20);
        end
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        marker_index = s.marker;
        pos_x = s.x;
        pos_y = s.y;
        pos_z = s.z;
        time_stamp = s.stamp;
        sample_valid = s.present;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        book.take_sample(s);
        if (s.present)
        begin
            gen_seeded[s.marker] = 1'b1;
            gen_x[s.marker] = s.x;
            gen_y[s.marker] = s.y;
            gen_z[s.marker] = s.z;
            gen_t[s.marker] = s.stamp;
        end
        else if (gen_seeded[s.marker])
        begin
            gen_t[s.marker] = s.stamp;
        end
    endtask

    task automatic hold_off();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        book.set_reg(idx, data);
    endtask

    task automatic load_regs(logic [31:0] jump, logic [31:0] speed, logic [31:0] gain_word,
                             logic [31:0] dt_word);
        write_reg(CFG_MAX_JUMP, jump);
        write_reg(CFG_MAX_VELOCITY, speed);
        write_reg(CFG_SMOOTHING_GAIN, gain_word);
        write_reg(CFG_DEFAULT_DT, dt_word);
    endtask

    task automatic run_random(int unsigned span, int unsigned send_pct, int unsigned recv_pct,
                              int count);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 63)
                hold_off();
            send_sample(next_sample(span));
        end
        wait_idle();
    endtask

    task automatic run_directed();
        // unseeded invalid, then a seed at the negative extreme
        send_sample(mk(4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_sample(mk(4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1000, 1'b1));
        send_sample(mk(4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd34333, 1'b1));
        // step exactly at the jump limit, then one past it
        send_sample(mk(4'd0, 32'h8000_2E14, 32'h8000_0000, 32'h8000_0000, 32'd1034333, 1'b1));
        send_sample(mk(4'd0, 32'h8000_5C29, 32'h8000_0000, 32'h8000_0000, 32'd2034333, 1'b1));
        send_sample(mk(4'd0, 32'd0, 32'd0, 32'd0, 32'd2034433, 1'b0));
        // repeated time, time going back, then a speed-only outlier
        send_sample(mk(4'd0, 32'h8000_5C8D, 32'h7FFF_FF9C, 32'h8000_0000, 32'd2034433, 1'b1));
        send_sample(mk(4'd0, 32'h8000_5CF1, 32'h7FFF_FF38, 32'h8000_0032, 32'd2030000, 1'b1));
        send_sample(mk(4'd0, 32'h8000_60D9, 32'h7FFF_FF38, 32'h8000_0032, 32'd2030001, 1'b1));
        // positive extreme with the time wrapping through zero
        send_sample(mk(4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 1'b1));
        send_sample(mk(4'd15, 32'h7FFF_FFCD, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h0000_8000, 1'b1));
        send_sample(mk(4'd15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b1));
        // small negative values; time difference of exactly half the range
        send_sample(mk(4'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        send_sample(mk(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd33333, 1'b1));
        send_sample(mk(4'd1, 32'hFFFF_FFF0, 32'd5, 32'hFFFF_FFFF, 32'h8000_8235, 1'b1));
        send_sample(mk(4'd7, 32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'h5555_AAAA, 1'b0));
        send_sample(mk(4'd7, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hAAAA_5555, 1'b1));
        send_sample(mk(4'd7, 32'h5555_555F, 32'hAAAA_AAA0, 32'h3333_3333, 32'hAAAA_D78A, 1'b1));
        send_sample(mk(4'd7, 32'h5555_5560, 32'hAAAA_AAA0, 32'h3333_3334, 32'hAAAA_D78A, 1'b0));
        wait_idle();
    endtask

    initial
    begin
        book = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_JUMP;
        cfg_data = '0;
        in_valid = 1'b0;
        marker_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        time_stamp = '0;
        sample_valid = 1'b0;
        for (int i = 0; i < MARKERS; i++)
        begin
            gen_seeded[i] = 1'b0;
            gen_x[i] = '0;
            gen_y[i] = '0;
            gen_z[i] = '0;
            gen_t[i] = $urandom;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(6000, 0, 0, 300);
        load_regs(32'h0010_0000, 32'h0064_0000, 32'h0001_0000, 32'd1000000);
        run_random(200000, 85, 0, 300);
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1);
        run_random(32'h0100_0000, 0, 85, 300);
        // zero limits and zero fallback time step
        load_regs(32'd0, 32'd0, 32'd1, 32'd0);
        run_random(4, 16, 16, 200);
        // gain word beyond one, upper bits set
        load_regs(32'd40000, 32'd2000000, 32'hFFFF_FFFF, 32'd20000);
        run_random(20000, 0, 0, 300);
        begin : random_regs
            logic [31:0] jump;
            jump = $urandom_range(200000, 1000);
            load_regs(jump, $urandom_range(10000000, 100000), $urandom, $urandom);
            run_random(jump / 2, 16, 16, 400);
        end

        if (book.mismatches == 0 && book.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
